// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue_core; no dependencies.
package spq_pkg;

  // Queue geometry and field widths
  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 4;
  localparam int STATUS_W = 2;

  // Opcodes
  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // take a new transaction from the input port
    logic walk;     // one step of the walk over the store
    logic place;    // write the last entry at the tail slot
    logic publish;  // load the result register and commit the count
  } spq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic walk_needed;  // accepted transaction has to walk the store
    logic walk_last;    // this walk step ends a poll walk
    logic need_place;   // this walk step ends an offer walk; tail slot still to write
  } spq_stat_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
// Sequencer for the sorted priority queue: accept, walk, place, publish.
// Depends on spq_pkg for the command and status structs.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PLACE,
    S_RESULT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Decode commands from the current state
  always_comb begin
    cmd.accept  = (state == S_IDLE) && in_valid;
    cmd.walk    = (state == S_WALK);
    cmd.place   = (state == S_PLACE);
    cmd.publish = (state == S_RESULT) && out_free;
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= stat.walk_needed ? S_WALK : S_RESULT;
          end
        end
        S_WALK: begin
          priority if (stat.walk_last) begin
            state <= S_RESULT;
          end else if (stat.need_place) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/spq_datapath.sv =====
// Entry store, walk index, count, head copy and result register of the queue.
// Depends on spq_pkg; driven by commands from spq_ctrl.
module spq_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  spq_pkg::spq_cmd_t             cmd,
  output spq_pkg::spq_stat_t            stat,
  input  logic                          cfg_write_en,
  input  logic                          cfg_write_data,
  input  logic                          opcode,
  input  logic [spq_pkg::KEY_W-1:0]     entry_key,
  input  logic [spq_pkg::PAY_W-1:0]     entry_payload,
  output logic [spq_pkg::STATUS_W-1:0]  status,
  output logic [spq_pkg::POS_W-1:0]     insert_position,
  output logic [spq_pkg::KEY_W-1:0]     removed_key,
  output logic [spq_pkg::PAY_W-1:0]     removed_payload,
  output logic                          head_valid,
  output logic [spq_pkg::KEY_W-1:0]     head_key,
  output logic [spq_pkg::PAY_W-1:0]     head_payload,
  output logic [spq_pkg::CNT_W-1:0]     entry_count
);

  // Entry store, one write and one registered read port
  logic [spq_pkg::KEY_W-1:0] key_mem [spq_pkg::DEPTH];
  logic [spq_pkg::PAY_W-1:0] pay_mem [spq_pkg::DEPTH];
  logic [spq_pkg::KEY_W-1:0] rd_key;
  logic [spq_pkg::PAY_W-1:0] rd_pay;

  // Working registers
  logic                         order_desc;
  logic [spq_pkg::CNT_W-1:0]    count;
  logic [spq_pkg::IDX_W-1:0]    idx;
  logic [spq_pkg::IDX_W-1:0]    idx_next;
  logic                         op;
  logic [spq_pkg::KEY_W-1:0]    new_key;
  logic [spq_pkg::PAY_W-1:0]    new_pay;
  logic [spq_pkg::STATUS_W-1:0] stat_code;
  logic [spq_pkg::POS_W-1:0]    pos;
  logic [spq_pkg::KEY_W-1:0]    rem_key;
  logic [spq_pkg::PAY_W-1:0]    rem_pay;
  logic [spq_pkg::KEY_W-1:0]    top_key;
  logic [spq_pkg::PAY_W-1:0]    top_pay;
  logic                         found;
  logic [spq_pkg::KEY_W-1:0]    carry_key;
  logic [spq_pkg::PAY_W-1:0]    carry_pay;

  // Write and read port controls
  logic                      we;
  logic [spq_pkg::IDX_W-1:0] waddr;
  logic [spq_pkg::KEY_W-1:0] wkey;
  logic [spq_pkg::PAY_W-1:0] wpay;
  logic [spq_pkg::IDX_W-1:0] raddr;

  logic [spq_pkg::CNT_W-1:0] count_m1;
  logic [spq_pkg::CNT_W-1:0] count_after;
  logic [spq_pkg::IDX_W-1:0] idx_p1;
  logic [spq_pkg::IDX_W-1:0] idx_m1;
  logic                      is_full;
  logic                      is_empty;
  logic                      goes_first;

  assign count_m1 = count - spq_pkg::CNT_W'(1);
  assign idx_p1   = idx + spq_pkg::IDX_W'(1);
  assign idx_m1   = idx - spq_pkg::IDX_W'(1);
  assign is_full  = (count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign is_empty = (count == '0);

  // New entry precedes the stored one read this cycle
  assign goes_first = order_desc ? (new_key > rd_key) : (new_key < rd_key);

  // Status toward the controller
  always_comb begin
    if (opcode == spq_pkg::OP_OFFER) begin
      stat.walk_needed = !is_empty && !is_full;
    end else begin
      stat.walk_needed = (count > spq_pkg::CNT_W'(1));
    end
    if (op == spq_pkg::OP_OFFER) begin
      stat.walk_last  = 1'b0;
      stat.need_place = (spq_pkg::CNT_W'(idx) == count_m1);
    end else begin
      stat.walk_last  = (spq_pkg::CNT_W'(idx) == count_m1);
      stat.need_place = 1'b0;
    end
  end

  // Steer the store ports for each command
  always_comb begin
    we       = 1'b0;
    waddr    = '0;
    wkey     = new_key;
    wpay     = new_pay;
    raddr    = idx;
    idx_next = idx;
    priority if (cmd.accept) begin
      if (opcode == spq_pkg::OP_OFFER) begin
        raddr = '0;
        if (is_empty) begin
          we   = 1'b1;
          wkey = entry_key;
          wpay = entry_payload;
        end
      end else begin
        raddr = spq_pkg::IDX_W'(1);
      end
      idx_next = raddr;
    end else if (cmd.walk) begin
      raddr    = idx_p1;
      idx_next = idx_p1;
      if (op == spq_pkg::OP_OFFER) begin
        // scan from the head; once placed, ripple displaced entries up one slot
        waddr = idx;
        if (found) begin
          we   = 1'b1;
          wkey = carry_key;
          wpay = carry_pay;
        end else if (goes_first) begin
          we = 1'b1;
        end
      end else begin
        we    = 1'b1;
        waddr = idx_m1;
        wkey  = rd_key;
        wpay  = rd_pay;
      end
    end else if (cmd.place) begin
      // tail slot gets the last displaced entry, or the new one if none
      we    = 1'b1;
      waddr = count[spq_pkg::IDX_W-1:0];
      if (found) begin
        wkey = carry_key;
        wpay = carry_pay;
      end
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      pay_mem[waddr] <= wpay;
    end
    rd_key <= key_mem[raddr];
    rd_pay <= pay_mem[raddr];
  end

  // Count after the pending transaction commits
  always_comb begin
    count_after = count;
    if (stat_code == spq_pkg::ST_OK) begin
      if (op == spq_pkg::OP_OFFER) begin
        count_after = count + spq_pkg::CNT_W'(1);
      end else begin
        count_after = count_m1;
      end
    end
  end

  // Control registers: order flag and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      order_desc <= 1'b0;
      count      <= '0;
    end else begin
      if (cfg_write_en) begin
        order_desc <= cfg_write_data;
      end
      if (cmd.publish) begin
        count <= count_after;
      end
    end
  end

  // Transaction registers, head copy and result register
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (we && (waddr == '0)) begin
      top_key <= wkey;
      top_pay <= wpay;
    end
    if (cmd.accept) begin
      op      <= opcode;
      new_key <= entry_key;
      new_pay <= entry_payload;
      pos     <= '0;
      rem_key <= '0;
      rem_pay <= '0;
      found   <= 1'b0;
      if (opcode == spq_pkg::OP_OFFER) begin
        stat_code <= is_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
      end else begin
        stat_code <= is_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
        if (!is_empty) begin
          rem_key <= top_key;
          rem_pay <= top_pay;
        end
      end
    end
    if (cmd.walk && (op == spq_pkg::OP_OFFER)) begin
      carry_key <= rd_key;
      carry_pay <= rd_pay;
      if (!found && goes_first) begin
        found <= 1'b1;
        pos   <= spq_pkg::POS_W'(idx);
      end
    end
    if (cmd.place && !found) begin
      pos <= spq_pkg::POS_W'(count);
    end
    if (cmd.publish) begin
      status          <= stat_code;
      insert_position <= pos;
      removed_key     <= rem_key;
      removed_payload <= rem_pay;
      entry_count     <= count_after;
      head_valid      <= (count_after != '0);
      head_key        <= (count_after != '0) ? top_key : '0;
      head_payload    <= (count_after != '0) ? top_pay : '0;
    end
  end

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  opcode, entry_key, entry_payload
//   output   out_valid/out_stall  status, insert_position, removed_key, removed_payload,
//                                 head_valid, head_key, head_payload, entry_count
//   config   cfg_write_en         cfg_write_data (order_descending)
//
// An offer into n entries (1 to 15) walks all n and places; a poll of n > 1 shifts n - 1 down.
// An offer scans from the head and ripples displaced entries up one slot per cycle.
// Full-queue offers, empty-queue polls and trivial cases skip the walk.
// rst is synchronous and clears the count and the order flag; the store is not cleared.
// A waiting result does not block the next accept; it blocks only the next publish.
module sorted_priority_queue_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic                          cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [spq_pkg::KEY_W-1:0]     entry_key,
  input  logic [spq_pkg::PAY_W-1:0]     entry_payload,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spq_pkg::STATUS_W-1:0]  status,
  output logic [spq_pkg::POS_W-1:0]     insert_position,
  output logic [spq_pkg::KEY_W-1:0]     removed_key,
  output logic [spq_pkg::PAY_W-1:0]     removed_payload,
  output logic                          head_valid,
  output logic [spq_pkg::KEY_W-1:0]     head_key,
  output logic [spq_pkg::PAY_W-1:0]     head_payload,
  output logic [spq_pkg::CNT_W-1:0]     entry_count
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t stat;

  // Sequencer
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store and result path
  spq_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .opcode          (opcode),
    .entry_key       (entry_key),
    .entry_payload   (entry_payload),
    .status          (status),
    .insert_position (insert_position),
    .removed_key     (removed_key),
    .removed_payload (removed_payload),
    .head_valid      (head_valid),
    .head_key        (head_key),
    .head_payload    (head_payload),
    .entry_count     (entry_count)
  );

endmodule

// ===== verif/sorted_priority_queue_core_tb.sv =====
// Self-checking testbench for sorted_priority_queue_core: offers and polls in both service orders.
// Depends on spq_pkg and the RTL of sorted_priority_queue_core; stands alone otherwise.
`timescale 1ns / 100ps

module sorted_priority_queue_core_tb;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PARK_CYCLES = 200;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic                      op;
    logic [spq_pkg::KEY_W-1:0] key;
    logic [spq_pkg::PAY_W-1:0] pay;
  } queue_req_t;

  typedef struct packed {
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::POS_W-1:0]    pos;
    logic [spq_pkg::KEY_W-1:0]    removed_key;
    logic [spq_pkg::PAY_W-1:0]    removed_pay;
    logic                         head_valid;
    logic [spq_pkg::KEY_W-1:0]    head_key;
    logic [spq_pkg::PAY_W-1:0]    head_pay;
    logic [spq_pkg::CNT_W-1:0]    count;
  } queue_resp_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write_en = 1'b0;
  logic                         cfg_write_data = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         opcode = spq_pkg::OP_OFFER;
  logic [spq_pkg::KEY_W-1:0]    entry_key = '0;
  logic [spq_pkg::PAY_W-1:0]    entry_payload = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic [spq_pkg::POS_W-1:0]    insert_position;
  logic [spq_pkg::KEY_W-1:0]    removed_key;
  logic [spq_pkg::PAY_W-1:0]    removed_payload;
  logic                         head_valid;
  logic [spq_pkg::KEY_W-1:0]    head_key;
  logic [spq_pkg::PAY_W-1:0]    head_payload;
  logic [spq_pkg::CNT_W-1:0]    entry_count;

  sorted_priority_queue_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .entry_key       (entry_key),
    .entry_payload   (entry_payload),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .insert_position (insert_position),
    .removed_key     (removed_key),
    .removed_payload (removed_payload),
    .head_valid      (head_valid),
    .head_key        (head_key),
    .head_payload    (head_payload),
    .entry_count     (entry_count)
  );

  // Shadow copy of the sorted store and the order flag
  logic [spq_pkg::KEY_W-1:0] shadow_key [spq_pkg::DEPTH];
  logic [spq_pkg::PAY_W-1:0] shadow_pay [spq_pkg::DEPTH];
  int                        shadow_count = 0;
  bit                        shadow_desc = 1'b0;

  queue_req_t  op_backlog[$];
  queue_resp_t owed_resp[$];

  int  sent_total = 0;
  int  taken_total = 0;
  int  results_seen = 0;
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  int  send_wait = 0;
  int  send_calm = 0;
  int  recv_wait = 0;
  int  recv_calm = 0;
  int  park_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one transaction to the shadow queue and return the response it owes
  function automatic queue_resp_t sorted_queue_step(queue_req_t req);
    queue_resp_t r;
    int          slot;
    bit          found;
    r = '0;
    r.status = spq_pkg::ST_OK;
    found = 1'b0;
    if (req.op == spq_pkg::OP_OFFER) begin
      if (shadow_count >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        slot = shadow_count;
        // find the first stored entry the new one strictly precedes
        for (int i = 0; i < shadow_count; i++) begin
          if (!found && (shadow_desc ? (req.key > shadow_key[i]) :
                                       (req.key < shadow_key[i]))) begin
            slot = i;
            found = 1'b1;
          end
        end
        for (int i = shadow_count; i > slot; i--) begin
          shadow_key[i] = shadow_key[i-1];
          shadow_pay[i] = shadow_pay[i-1];
        end
        shadow_key[slot] = req.key;
        shadow_pay[slot] = req.pay;
        shadow_count++;
        r.pos = spq_pkg::POS_W'(slot);
      end
    end else if (shadow_count == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.removed_key = shadow_key[0];
      r.removed_pay = shadow_pay[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_key[i-1] = shadow_key[i];
        shadow_pay[i-1] = shadow_pay[i];
      end
      shadow_count--;
    end
    if (shadow_count > 0) begin
      r.head_valid = 1'b1;
      r.head_key = shadow_key[0];
      r.head_pay = shadow_pay[0];
    end
    r.count = spq_pkg::CNT_W'(shadow_count);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, name, want, got);
    end
  endfunction

  // Draw an idle count; now and then run a calm stretch with no idling
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Accept transactions, predict, check results, and watch for a hang
  always @(posedge clk) begin : scoreboard
    queue_req_t  req;
    queue_resp_t want;
    in_took = 1'b0;
    out_took = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        req.op = opcode;
        req.key = entry_key;
        req.pay = entry_payload;
        owed_resp.push_back(sorted_queue_step(req));
        in_took = 1'b1;
        taken_total++;
      end
      if (out_valid && !out_stall) begin
        out_took = 1'b1;
        results_seen++;
        if (owed_resp.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("result %0d: unexpected transaction, status 0x%0h", results_seen, status);
        end else begin
          want = owed_resp.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("insert_position", 32'(want.pos), 32'(insert_position));
          check_field("removed_key", want.removed_key, removed_key);
          check_field("removed_payload", want.removed_pay, removed_payload);
          check_field("head_valid", 32'(want.head_valid), 32'(head_valid));
          check_field("head_key", want.head_key, head_key);
          check_field("head_payload", want.head_pay, head_payload);
          check_field("entry_count", 32'(want.count), 32'(entry_count));
        end
      end
      if (in_took || out_took) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer the next backlog item after a random gap; hold it while stalled
  always @(negedge clk) begin : op_driver
    queue_req_t req;
    bit         drive;
    drive = in_valid;
    if (rst) begin
      drive = 1'b0;
    end else begin
      if (in_took) drive = 1'b0;
      if (!drive) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (op_backlog.size() > 0) begin
          req = op_backlog.pop_front();
          opcode <= req.op;
          entry_key <= req.key;
          entry_payload <= req.pay;
          drive = 1'b1;
          send_wait = draw_wait(send_calm);
        end
      end
    end
    in_valid <= drive;
  end

  // Stall results at random; park for a long stretch twice to back up the input
  always @(negedge clk) begin : result_sink
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_took) begin
        recv_wait = draw_wait(recv_calm);
        if (results_seen == 60 || results_seen == 260) park_left = PARK_CYCLES;
      end
      if (park_left > 0) begin
        park_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_op(logic op, logic [spq_pkg::KEY_W-1:0] key,
                         logic [spq_pkg::PAY_W-1:0] pay);
    queue_req_t req;
    req.op = op;
    req.key = key;
    req.pay = pay;
    op_backlog.push_back(req);
    sent_total++;
  endtask

  // Hold until every queued transaction is taken and answered
  task automatic wait_idle();
    @(negedge clk);
    while (taken_total != sent_total || owed_resp.size() != 0) @(negedge clk);
  endtask

  task automatic set_order(bit desc);
    cfg_write_en <= 1'b1;
    cfg_write_data <= desc;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    shadow_desc = desc;
    @(posedge clk);
  endtask

  // Bursts that lean toward offers or polls or balance them, so the queue swings full and empty
  task automatic queue_random_ops(int n);
    int                        burst;
    int                        offer_pct;
    logic                      op;
    logic [spq_pkg::KEY_W-1:0] key;
    logic [spq_pkg::PAY_W-1:0] pay;
    burst = 0;
    offer_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(8, 24);
        case ($urandom_range(0, 2))
          0: offer_pct = 85;
          1: offer_pct = 15;
          default: offer_pct = 50;
        endcase
      end
      burst--;
      op = ($urandom_range(0, 99) < offer_pct) ? spq_pkg::OP_OFFER : spq_pkg::OP_POLL;
      case ($urandom_range(0, 3))
        0: key = $urandom_range(0, 7);
        1: begin
          case ($urandom_range(0, 3))
            0: key = '0;
            1: key = '1;
            2: key = 32'h0000_0001;
            default: key = 32'hFFFF_FFFE;
          endcase
        end
        2: key = 32'h8000_0000 + $urandom_range(0, 3) - 2;
        default: key = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0: pay = '0;
        1: pay = '1;
        default: pay = $urandom;
      endcase
      push_op(op, key, pay);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_order(1'b0);

    // Directed: empty poll, extremes, equal keys, fill to full, full offer, polls
    push_op(spq_pkg::OP_POLL, $urandom, $urandom);
    push_op(spq_pkg::OP_OFFER, 32'h0000_0000, 32'hFFFF_FFFF);
    push_op(spq_pkg::OP_OFFER, 32'hFFFF_FFFF, 32'h0000_0000);
    push_op(spq_pkg::OP_OFFER, 32'h0000_0000, 32'h0000_0001);
    push_op(spq_pkg::OP_OFFER, 32'd100, 32'h0000_0002);
    push_op(spq_pkg::OP_OFFER, 32'd100, 32'h0000_0003);
    push_op(spq_pkg::OP_OFFER, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
    push_op(spq_pkg::OP_OFFER, 32'h8000_0000, 32'h5A5A_5A5A);
    push_op(spq_pkg::OP_OFFER, 32'h0000_0001, 32'h0000_0004);
    push_op(spq_pkg::OP_OFFER, 32'hFFFF_FFFE, 32'h0000_0005);
    push_op(spq_pkg::OP_OFFER, 32'hFFFF_FFFF, 32'h0000_0006);
    push_op(spq_pkg::OP_OFFER, 32'd50, 32'h0000_0007);
    push_op(spq_pkg::OP_OFFER, 32'd50, 32'h0000_0008);
    push_op(spq_pkg::OP_OFFER, 32'd3, 32'h0000_0009);
    push_op(spq_pkg::OP_OFFER, 32'd2, 32'h0000_000A);
    push_op(spq_pkg::OP_OFFER, 32'd1, 32'h0000_000B);
    push_op(spq_pkg::OP_OFFER, 32'd0, 32'h0000_000C);
    push_op(spq_pkg::OP_OFFER, 32'd9, 32'hDEAD_BEEF);
    push_op(spq_pkg::OP_POLL, '1, '1);
    push_op(spq_pkg::OP_POLL, '0, '0);
    push_op(spq_pkg::OP_POLL, $urandom, $urandom);
    wait_idle();

    // Random phases, flipping the service order with entries still held
    for (int phase = 0; phase < 4; phase++) begin
      set_order(phase % 2 == 0);
      queue_random_ops(100);
      wait_idle();
    end

    repeat (40) @(negedge clk);
    if (fail_count == 0 && owed_resp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue_core.sv
verif/sorted_priority_queue_core_tb.sv
